/* design/renc_pkg.sv */
// Shared types, constants and helpers of the rotary encoder mode counter.
package renc_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int REM_W          = 7;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    localparam logic [2:0] REG_SETTLE      = 3'd0;
    localparam logic [2:0] REG_ROT_LOCKOUT = 3'd1;
    localparam logic [2:0] REG_BTN_LOCKOUT = 3'd2;
    localparam logic [2:0] REG_WRAP_ZERO   = 3'd3;
    localparam logic [2:0] REG_WRAP_ONE    = 3'd4;
    localparam logic [2:0] REG_MODE_COUNT  = 3'd5;

    localparam logic [15:0] SETTLE_RST      = 16'd8;
    localparam logic [15:0] ROT_LOCKOUT_RST = 16'd15;
    localparam logic [15:0] BTN_LOCKOUT_RST = 16'd150;
    localparam logic [5:0]  WRAP_ZERO_RST   = 6'd8;
    localparam logic [5:0]  WRAP_ONE_RST    = 6'd40;
    localparam logic [2:0]  MODE_COUNT_RST  = 3'd3;

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    typedef struct packed {
        logic             start;
        logic [REM_W-1:0] value;
        logic [REM_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic step_up;
        logic step_down;
        logic press;
        logic checking;
    } t_check_evt;

    // A modulus of zero acts as the plain six-bit wrap.
    function automatic logic [REM_W-1:0] eff_wrap(input logic [5:0] w);
        eff_wrap = (w == 6'd0) ? 7'd64 : {1'b0, w};
    endfunction

endpackage

/* design/renc_rem.sv */
// Iterative subtractive remainder unit shared by the position and mode updates.
module renc_rem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  renc_pkg::t_rem_req        i_req,
    output logic                      o_busy,
    output logic [renc_pkg::REM_W-1:0] o_result
);
    import renc_pkg::*;

    logic             r_busy;
    logic [REM_W-1:0] r_val;
    logic [REM_W-1:0] r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_val < r_div)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_val <= i_req.value;
            r_div <= i_req.divisor;
        end else if (r_busy && (r_val >= r_div)) begin
            r_val <= r_val - r_div;
        end
    end

    assign o_busy   = r_busy;
    assign o_result = r_val;

endmodule

/* design/renc_check.sv */
// Edge detection, lockout counters and settle-window stability checks.
module renc_check #(
    parameter int COUNT_BITS = renc_pkg::COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_strobe,
    input  logic                 i_pin_a,
    input  logic                 i_pin_b,
    input  logic                 i_button_level,
    input  logic [15:0]          i_settle_ticks,
    input  logic [15:0]          i_rot_lockout,
    input  logic [15:0]          i_btn_lockout,
    output renc_pkg::t_check_evt o_evt
);
    import renc_pkg::*;

    localparam int SC_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int SN_W = (COUNT_BITS + 1 > 16) ? COUNT_BITS + 1 : 16;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_FIRST  = 3'b010,
        PH_SECOND = 3'b100
    } t_phase;

    typedef enum logic [3:0] {
        K_NONE = 4'b0001,
        K_A    = 4'b0010,
        K_B    = 4'b0100,
        K_BTN  = 4'b1000
    } t_kind;

    logic [2:0]            r_prev, n_prev;
    t_phase                r_phase, n_phase;
    t_kind                 r_kind, n_kind;
    logic                  r_ref, n_ref;
    logic [COUNT_BITS-1:0] r_settle, n_settle;
    logic [COUNT_BITS:0]   r_since_rot, n_since_rot;
    logic [COUNT_BITS:0]   r_since_btn, n_since_btn;
    t_check_evt            r_evt, n_evt;

    always_comb begin
        logic                  sample;
        logic                  edge_pin;
        logic                  ok;
        logic                  rot_hit;
        logic                  btn_hit;
        logic                  fall_a;
        logic                  fall_b;
        logic                  rise_btn;
        logic                  rot_ok;
        logic                  btn_ok;
        logic [COUNT_BITS-1:0] settle_inc;
        logic [15:0]           window;

        n_prev   = {i_button_level, i_pin_b, i_pin_a};
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_ref    = r_ref;
        n_settle = r_settle;
        n_evt    = '0;
        rot_hit  = 1'b0;
        btn_hit  = 1'b0;
        sample   = 1'b0;
        edge_pin = 1'b0;
        ok       = 1'b1;
        window     = (i_settle_ticks == 16'd0) ? 16'd1 : i_settle_ticks;
        settle_inc = (&r_settle) ? r_settle : r_settle + 1'b1;
        fall_a   = r_prev[0] & ~i_pin_a;
        fall_b   = r_prev[1] & ~i_pin_b;
        rise_btn = ~r_prev[2] & i_button_level;
        rot_ok   = SN_W'(r_since_rot) > SN_W'(i_rot_lockout);
        btn_ok   = SN_W'(r_since_btn) > SN_W'(i_btn_lockout);

        case (r_phase)
            PH_IDLE: begin
                if (fall_a && rot_ok) begin
                    n_kind   = K_A;
                    n_ref    = i_pin_b;
                    n_phase  = PH_FIRST;
                    n_settle = '0;
                end else if (fall_b && rot_ok) begin
                    n_kind   = K_B;
                    n_ref    = i_pin_a;
                    n_phase  = PH_FIRST;
                    n_settle = '0;
                end else if (rise_btn && btn_ok) begin
                    n_kind   = K_BTN;
                    n_ref    = i_button_level;
                    n_phase  = PH_FIRST;
                    n_settle = '0;
                end
            end
            PH_FIRST, PH_SECOND: begin
                case (r_kind)
                    K_A: begin
                        sample   = (r_phase == PH_FIRST) ? i_pin_b : i_pin_a;
                        edge_pin = i_pin_a;
                    end
                    K_B: begin
                        sample   = (r_phase == PH_FIRST) ? i_pin_a : i_pin_b;
                        edge_pin = i_pin_b;
                    end
                    K_BTN: begin
                        sample   = i_button_level;
                        edge_pin = i_button_level;
                        ok       = (r_phase == PH_FIRST);
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
                if (!ok) begin
                    n_phase  = PH_IDLE;
                    n_kind   = K_NONE;
                    n_settle = '0;
                end else begin
                    n_settle = settle_inc;
                    if (SC_W'(settle_inc) >= SC_W'(window)) begin
                        if (sample != r_ref) begin
                            n_ref    = sample;
                            n_settle = '0;
                        end else if (r_kind == K_BTN) begin
                            if (r_ref) begin
                                n_evt.press = 1'b1;
                                btn_hit     = 1'b1;
                            end
                            n_phase  = PH_IDLE;
                            n_kind   = K_NONE;
                            n_settle = '0;
                        end else if (r_phase == PH_FIRST) begin
                            if (r_ref) begin
                                n_phase = PH_SECOND;
                                n_ref   = edge_pin;
                            end else begin
                                n_phase = PH_IDLE;
                                n_kind  = K_NONE;
                            end
                            n_settle = '0;
                        end else begin
                            if (!r_ref) begin
                                n_evt.step_up   = (r_kind == K_A);
                                n_evt.step_down = (r_kind != K_A);
                                rot_hit         = 1'b1;
                            end
                            n_phase  = PH_IDLE;
                            n_kind   = K_NONE;
                            n_settle = '0;
                        end
                    end
                end
            end
            default: begin
                n_phase  = PH_IDLE;
                n_kind   = K_NONE;
                n_settle = '0;
            end
        endcase

        n_evt.checking = (n_phase != PH_IDLE);
        n_since_rot = rot_hit ? '0 : ((&r_since_rot) ? r_since_rot : r_since_rot + 1'b1);
        n_since_btn = btn_hit ? '0 : ((&r_since_btn) ? r_since_btn : r_since_btn + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= 3'b011;
            r_phase     <= PH_IDLE;
            r_kind      <= K_NONE;
            r_ref       <= 1'b0;
            r_settle    <= '0;
            r_since_rot <= '0;
            r_since_btn <= '0;
            r_evt       <= '0;
        end else if (i_strobe) begin
            r_prev      <= n_prev;
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_ref       <= n_ref;
            r_settle    <= n_settle;
            r_since_rot <= n_since_rot;
            r_since_btn <= n_since_btn;
            r_evt       <= n_evt;
        end
    end

    assign o_evt = r_evt;

endmodule

/* design/rotary_encoder_mode_counter.sv */
// Top level of the debounced rotary encoder counter with button-selected mode.
//
// One input word carries the sampled levels of encoder pins A and B and of
// the push button for one tick. The block answers every input word with one
// output word: wrapped position, mode index, toggle flag, step and press
// events, and whether a stability check is still running.
// Both channels use valid and ready. The input side is ready only while the
// sequencer is idle; one word is worked on at a time.
// The work is done by the shared subtractive remainder unit, which removes
// one modulus per cycle while busy: for the mode advance, for the position
// step and, in modes zero and one, for the reduction of the position by the
// modulus of the new mode, which takes up to 63 passes when that modulus is one.
// The finished word sits in an output register; a new input word is accepted
// while it waits, and the sequencer holds its next result until the
// receiver takes the waiting one.
// The configuration registers sit on an APB-style port and may be written
// only while the block is idle. Synchronous reset restores the register
// defaults, clears position, mode and toggle, and empties the output.
module rotary_encoder_mode_counter #(
    parameter int COUNT_BITS = renc_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_pin_a,
    input  logic                        i_pin_b,
    input  logic                        i_button_level,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [5:0]                  o_position,
    output logic [2:0]                  o_mode_index,
    output logic                        o_toggle_out,
    output logic [1:0]                  o_step_event,
    output logic                        o_press_event,
    output logic                        o_checking,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [renc_pkg::ADDR_W-1:0] paddr,
    input  logic [renc_pkg::DATA_W-1:0] pwdata,
    output logic [renc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import renc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EVENT = 8'b0000_0010,
        S_MODE  = 8'b0000_0100,
        S_POS   = 8'b0000_1000,
        S_PWAIT = 8'b0001_0000,
        S_WRAP  = 8'b0010_0000,
        S_RWAIT = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_settle_ticks;
    logic [15:0] r_rot_lockout;
    logic [15:0] r_btn_lockout;
    logic [5:0]  r_wrap_zero;
    logic [5:0]  r_wrap_one;
    logic [2:0]  r_mode_count;
    logic [5:0]  r_pos, n_pos;
    logic [2:0]  r_mode, n_mode;
    logic        r_toggle, n_toggle;
    logic [5:0]  r_cur_wrap, n_cur_wrap;
    logic        r_out_valid;
    logic [5:0]  r_out_pos;
    logic [2:0]  r_out_mode;
    logic        r_out_toggle;
    logic [1:0]  r_out_step;
    logic        r_out_press;
    logic        r_out_checking;

    logic        accept;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    t_rem_req    rem_req;
    logic        rem_busy;
    logic [REM_W-1:0] rem_result;
    t_check_evt  evt;
    logic [REM_W-1:0] w_eff;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RST;
            r_rot_lockout  <= ROT_LOCKOUT_RST;
            r_btn_lockout  <= BTN_LOCKOUT_RST;
            r_wrap_zero    <= WRAP_ZERO_RST;
            r_wrap_one     <= WRAP_ONE_RST;
            r_mode_count   <= MODE_COUNT_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SETTLE:      r_settle_ticks <= pwdata[15:0];
                REG_ROT_LOCKOUT: r_rot_lockout  <= pwdata[15:0];
                REG_BTN_LOCKOUT: r_btn_lockout  <= pwdata[15:0];
                REG_WRAP_ZERO:   r_wrap_zero    <= pwdata[5:0];
                REG_WRAP_ONE:    r_wrap_one     <= pwdata[5:0];
                REG_MODE_COUNT:  r_mode_count   <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_SETTLE:      prdata = {16'd0, r_settle_ticks};
            REG_ROT_LOCKOUT: prdata = {16'd0, r_rot_lockout};
            REG_BTN_LOCKOUT: prdata = {16'd0, r_btn_lockout};
            REG_WRAP_ZERO:   prdata = {26'd0, r_wrap_zero};
            REG_WRAP_ONE:    prdata = {26'd0, r_wrap_one};
            REG_MODE_COUNT:  prdata = {29'd0, r_mode_count};
            default:         prdata = '0;
        endcase
    end

    renc_check #(
        .COUNT_BITS (COUNT_BITS)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_strobe       (accept),
        .i_pin_a        (i_pin_a),
        .i_pin_b        (i_pin_b),
        .i_button_level (i_button_level),
        .i_settle_ticks (r_settle_ticks),
        .i_rot_lockout  (r_rot_lockout),
        .i_btn_lockout  (r_btn_lockout),
        .o_evt          (evt)
    );

    renc_rem u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (rem_req),
        .o_busy   (rem_busy),
        .o_result (rem_result)
    );

    assign w_eff = eff_wrap(r_cur_wrap);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_mode     = r_mode;
        n_toggle   = r_toggle;
        n_cur_wrap = r_cur_wrap;
        rem_req    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVENT;
                end
            end
            S_EVENT: begin
                if (evt.press) begin
                    n_toggle = ~r_toggle;
                    if (r_mode_count == 3'd0) begin
                        n_mode  = 3'd0;
                        n_state = S_POS;
                    end else begin
                        rem_req.start   = 1'b1;
                        rem_req.value   = REM_W'(r_mode) + 1'b1;
                        rem_req.divisor = REM_W'(r_mode_count);
                        n_state = S_MODE;
                    end
                end else begin
                    n_state = S_POS;
                end
            end
            S_MODE: begin
                if (!rem_busy) begin
                    n_mode  = rem_result[2:0];
                    n_state = S_POS;
                end
            end
            S_POS: begin
                rem_req.start   = 1'b1;
                rem_req.divisor = w_eff;
                if (evt.step_up) begin
                    rem_req.value = REM_W'(r_pos) + 1'b1;
                end else if (evt.step_down) begin
                    rem_req.value = REM_W'(r_pos) + w_eff - 1'b1;
                end else begin
                    rem_req.value = REM_W'(r_pos);
                end
                n_state = S_PWAIT;
            end
            S_PWAIT: begin
                if (!rem_busy) begin
                    n_pos   = rem_result[5:0];
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (r_mode == 3'd0 || r_mode == 3'd1) begin
                    n_cur_wrap      = (r_mode == 3'd0) ? r_wrap_zero : r_wrap_one;
                    rem_req.start   = 1'b1;
                    rem_req.value   = REM_W'(r_pos);
                    rem_req.divisor = eff_wrap(n_cur_wrap);
                    n_state = S_RWAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RWAIT: begin
                if (!rem_busy) begin
                    n_pos   = rem_result[5:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= 6'd0;
            r_mode      <= 3'd0;
            r_toggle    <= 1'b0;
            r_cur_wrap  <= WRAP_ZERO_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_mode     <= n_mode;
            r_toggle   <= n_toggle;
            r_cur_wrap <= n_cur_wrap;
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
            r_out_pos      <= r_pos;
            r_out_mode     <= r_mode;
            r_out_toggle   <= r_toggle;
            r_out_step     <= evt.step_up ? STEP_UP : (evt.step_down ? STEP_DOWN : STEP_NONE);
            r_out_press    <= evt.press;
            r_out_checking <= evt.checking;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_position    = r_out_pos;
    assign o_mode_index  = r_out_mode;
    assign o_toggle_out  = r_out_toggle;
    assign o_step_event  = r_out_step;
    assign o_press_event = r_out_press;
    assign o_checking    = r_out_checking;

endmodule
